// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion helpers shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds whenever the antecedent does, same edge
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/psgde_pkg.sv
// ---------------------------------------------------------------------------
// psgde_pkg
// types and constants of the sound chip register delta encoder
// ---------------------------------------------------------------------------
package psgde_pkg;

   localparam int TONE_CHANNELS = 3;
   localparam int REG_COUNT     = 14;
   localparam int SLOT_COUNT    = 15;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [7:0] MIXER_MASK = 8'h3F;
   localparam logic [7:0] MIXER_TAG  = 8'hC0;
   localparam logic [7:0] FLAG_BIT   = 8'h80;

   typedef struct packed {
      logic [7:0]  mixer_bits;
      logic [11:0] tone_a_period;
      logic [11:0] tone_b_period;
      logic [11:0] tone_c_period;
      logic [15:0] envelope_period;
      logic [4:0]  noise_period;
      logic [4:0]  level_a;
      logic [4:0]  level_b;
      logic [4:0]  level_c;
      logic [3:0]  envelope_shape;
      logic [3:0]  retrigger_flags;
      logic [1:0]  frame_flags;
   } req_word_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } rsp_word_type;

   // fixed byte layout of a record; slot_en marks the bytes that go out
   typedef struct packed {
      logic [SLOT_COUNT-1:0]      slot_en;
      logic [SLOT_COUNT-1:0][7:0] slot_byte;
   } record_type;

   typedef struct packed {
      logic       valid;
      record_type rec;
   } queue_head_type;

endpackage

// File: rtl/psgde_front.sv
// ---------------------------------------------------------------------------
// psgde_front
// compares a register snapshot with the previous frame and builds a record
// ---------------------------------------------------------------------------
module psgde_front import psgde_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   input  logic         queue_full,
   output logic         push_valid,
   output record_type   push_rec
);

   localparam int REG_NOISE  = 6;
   localparam int REG_MIXER  = 7;
   localparam int REG_LEVEL  = 8;
   localparam int REG_ENV_L  = 11;
   localparam int REG_ENV_H  = 12;
   localparam int REG_SHAPE  = 13;

   localparam int SLOT_MASK  = 0;
   localparam int SLOT_MIXER = 1;
   localparam int SLOT_TONE  = 2;
   localparam int SLOT_ENV   = 8;
   localparam int SLOT_LEV_A = 10;
   localparam int SLOT_NOISE = 11;
   localparam int SLOT_LEV_B = 12;
   localparam int SLOT_SHAPE = 13;
   localparam int SLOT_LEV_C = 14;

   logic [7:0]  prev_ff [REG_COUNT];
   logic [7:0]  cur     [REG_COUNT];
   logic [11:0] tone    [TONE_CHANNELS];
   logic        accept;
   logic        force_key;
   logic        emit;
   logic        noise_set;
   logic        shape_set;
   logic        chg_a;
   logic        chg_b;
   logic        chg_c;
   logic        chg_env;
   logic        chg_mix;
   logic [TONE_CHANNELS-1:0] chg_tone;
   logic [7:0]  mask;
   record_type  rec;

   assign accept    = req_valid && !req_stall;
   assign req_stall = queue_full;
   assign force_key = req_word.frame_flags[0];
   assign emit      = req_word.frame_flags[1];

   assign tone[0] = req_word.tone_a_period;
   assign tone[1] = req_word.tone_b_period;
   assign tone[2] = req_word.tone_c_period;

   always_comb begin
      for (int i = 0; i < TONE_CHANNELS; i++) begin
         cur[2*i]   = tone[i][7:0];
         cur[2*i+1] = {4'h0, tone[i][11:8]};
      end
      cur[REG_NOISE]   = {3'h0, req_word.noise_period};
      cur[REG_MIXER]   = req_word.mixer_bits;
      cur[REG_LEVEL]   = {3'h0, req_word.level_a};
      cur[REG_LEVEL+1] = {3'h0, req_word.level_b};
      cur[REG_LEVEL+2] = {3'h0, req_word.level_c};
      cur[REG_ENV_L]   = req_word.envelope_period[7:0];
      cur[REG_ENV_H]   = req_word.envelope_period[15:8];
      cur[REG_SHAPE]   = {4'h0, req_word.envelope_shape};
   end

   always_comb begin
      rec = '0;

      // mixer high bits are kept but never compared
      chg_mix = ((cur[REG_MIXER] & MIXER_MASK) != (prev_ff[REG_MIXER] & MIXER_MASK))
                || force_key;
      rec.slot_en[SLOT_MIXER]   = chg_mix;
      rec.slot_byte[SLOT_MIXER] = (cur[REG_MIXER] & MIXER_MASK) | MIXER_TAG;

      for (int i = 0; i < TONE_CHANNELS; i++) begin
         chg_tone[i] = (cur[2*i] != prev_ff[2*i]) || (cur[2*i+1] != prev_ff[2*i+1])
                       || req_word.retrigger_flags[i] || force_key;
         rec.slot_en[SLOT_TONE+2*i]     = chg_tone[i];
         rec.slot_en[SLOT_TONE+2*i+1]   = chg_tone[i];
         rec.slot_byte[SLOT_TONE+2*i]   = cur[2*i];
         rec.slot_byte[SLOT_TONE+2*i+1] = cur[2*i+1]
                                          | (req_word.retrigger_flags[i] ? FLAG_BIT : 8'h00);
      end

      chg_env = (cur[REG_ENV_L] != prev_ff[REG_ENV_L])
                || (cur[REG_ENV_H] != prev_ff[REG_ENV_H]) || force_key;
      rec.slot_en[SLOT_ENV]     = chg_env;
      rec.slot_en[SLOT_ENV+1]   = chg_env;
      rec.slot_byte[SLOT_ENV]   = cur[REG_ENV_L];
      rec.slot_byte[SLOT_ENV+1] = cur[REG_ENV_H];

      noise_set = cur[REG_NOISE] != prev_ff[REG_NOISE];
      chg_a     = (cur[REG_LEVEL] != prev_ff[REG_LEVEL]) || noise_set || force_key;
      rec.slot_en[SLOT_LEV_A]   = chg_a;
      rec.slot_byte[SLOT_LEV_A] = cur[REG_LEVEL] | (noise_set ? FLAG_BIT : 8'h00);
      rec.slot_en[SLOT_NOISE]   = chg_a && noise_set;
      rec.slot_byte[SLOT_NOISE] = cur[REG_NOISE];

      shape_set = (cur[REG_SHAPE] != prev_ff[REG_SHAPE]) || req_word.retrigger_flags[3];
      chg_b     = (cur[REG_LEVEL+1] != prev_ff[REG_LEVEL+1]) || shape_set || force_key;
      rec.slot_en[SLOT_LEV_B]   = chg_b;
      rec.slot_byte[SLOT_LEV_B] = cur[REG_LEVEL+1] | (shape_set ? FLAG_BIT : 8'h00);
      rec.slot_en[SLOT_SHAPE]   = chg_b && shape_set;
      rec.slot_byte[SLOT_SHAPE] = cur[REG_SHAPE];

      chg_c = (cur[REG_LEVEL+2] != prev_ff[REG_LEVEL+2]) || force_key;
      rec.slot_en[SLOT_LEV_C]   = chg_c;
      rec.slot_byte[SLOT_LEV_C] = cur[REG_LEVEL+2];

      mask = {chg_mix, chg_tone[0], chg_tone[1], chg_tone[2], chg_env, chg_a, chg_b, chg_c};
      rec.slot_en[SLOT_MASK]   = 1'b1;
      rec.slot_byte[SLOT_MASK] = mask;
   end

   assign push_valid = accept && emit;
   assign push_rec   = rec;

   // copy is refreshed whether or not the frame is emitted
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            prev_ff[i] <= '0;
         end
      end else if (accept) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            prev_ff[i] <= cur[i];
         end
      end
   end

endmodule

// File: rtl/psgde_queue.sv
// ---------------------------------------------------------------------------
// psgde_queue
// two-entry record queue between the compare front and the byte sequencer
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psgde_queue import psgde_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   input  record_type     push_rec,
   output logic           queue_full,
   input  logic           pop,
   output queue_head_type head
);

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   record_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               do_pop;

   assign queue_full = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.rec   = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push_valid, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   `ASSERT_ALWAYS(a_no_overflow, clock, reset, !(push_valid && queue_full), "push into full queue")
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= COUNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

// File: rtl/psgde_back.sv
// ---------------------------------------------------------------------------
// psgde_back
// sends the enabled bytes of a record one word per cycle while not stalled
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module psgde_back import psgde_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_word_type   rsp_word
);

   record_type            rec_ff;
   record_type            rec_in;
   logic [SLOT_COUNT-1:0] pending_ff;
   logic [SLOT_COUNT-1:0] pending_in;
   logic                  busy_ff;
   logic                  busy_in;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   rsp_word_type          out_word_ff;
   rsp_word_type          out_word_in;
   logic [SLOT_COUNT-1:0] pick;
   logic [SLOT_COUNT-1:0] remaining;
   logic [7:0]            sel_byte;
   logic                  load;
   logic                  send;
   logic                  finishing;

   assign load      = !out_valid_ff || !rsp_stall;
   assign send      = busy_ff && load;
   // lowest pending slot goes next
   assign pick      = pending_ff & (~pending_ff + 1'b1);
   assign remaining = pending_ff & ~pick;
   assign finishing = send && (remaining == '0);
   assign pop       = head.valid && (!busy_ff || finishing);

   always_comb begin
      sel_byte = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         sel_byte = sel_byte | (rec_ff.slot_byte[i] & {8{pick[i]}});
      end
   end

   always_comb begin
      rec_in       = rec_ff;
      pending_in   = pending_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (pop) begin
         rec_in     = head.rec;
         pending_in = head.rec.slot_en;
         busy_in    = 1'b1;
      end else if (finishing) begin
         pending_in = '0;
         busy_in    = 1'b0;
      end else if (send) begin
         pending_in = remaining;
      end
      if (load) begin
         out_valid_in          = send;
         out_word_in.data_byte = sel_byte;
         out_word_in.last_byte = (remaining == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff      <= rec_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   `ASSERT_IMPLY(a_busy_pending, clock, reset, busy_ff, pending_ff != '0, "busy with no pending byte")
   `ASSERT_IMPLY(a_mid_record, clock, reset, rsp_valid && !rsp_word.last_byte, busy_ff, "record ended before last word")

endmodule

// File: rtl/psg_register_delta_encoder_unit.sv
// ---------------------------------------------------------------------------
// psg_register_delta_encoder_unit
// encodes each frame's sound chip register snapshot as a mask byte plus
// the register groups that changed since the previous frame
// ---------------------------------------------------------------------------
// a snapshot's record goes to the queue, the sequencer's record register and then
//    its first word to the output register; a record of 1 to 15 words is sent back
//    to back while not stalled, the next one loaded with its last word; emit off
//    pushes nothing; snapshots go back to back while the two-entry queue has room
// reset: synchronous, clears the previous-frame copy to zero and empties the queue
module psg_register_delta_encoder_unit import psgde_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic           queue_full;
   logic           push_valid;
   record_type     push_rec;
   logic           pop;
   queue_head_type head;

   psgde_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_rec   (push_rec)
   );

   psgde_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .queue_full (queue_full),
      .pop        (pop),
      .head       (head)
   );

   psgde_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

// File: test/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// drives register snapshots into psg_register_delta_encoder_unit and checks
// every output word against a frame-by-frame copy of the register file kept
// here: directed corner frames, random frame sequences, a long output
// hold-off and a back-to-back stretch
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import psgde_pkg::*;

   // register file layout of the kept copy
   localparam int R_NOISE   = 6;
   localparam int R_MIXER   = 7;
   localparam int R_LEVEL_A = 8;
   localparam int R_LEVEL_B = 9;
   localparam int R_LEVEL_C = 10;
   localparam int R_ENV_LO  = 11;
   localparam int R_ENV_HI  = 12;
   localparam int R_SHAPE   = 13;

   // mask byte bits
   localparam int M_MIXER   = 7;
   localparam int M_TONE_A  = 6;
   localparam int M_ENV     = 3;
   localparam int M_LEVEL_A = 2;
   localparam int M_LEVEL_B = 1;
   localparam int M_LEVEL_C = 0;

   // flag bits
   localparam int FF_KEYFRAME = 0;
   localparam int FF_EMIT     = 1;
   localparam int RT_SHAPE    = 3;

   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   logic [7:0]   kept_regs [REG_COUNT];
   rsp_word_type expected_bytes [$];
   req_word_type last_frame = '0;
   bit           gaps_on = 1'b1;
   int           hold_request = 0;
   int           hold_left = 0;
   int           stall_left = 0;
   int           fail_count = 0;
   int           frames_sent = 0;
   int           words_checked = 0;
   int           cycle_count = 0;

   psg_register_delta_encoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // expected record of one snapshot; the kept copy is replaced either way
   function automatic void predict_record(input req_word_type w);
      logic [7:0]  cur [REG_COUNT];
      logic [7:0]  rec [$];
      logic [11:0] tone [TONE_CHANNELS];
      logic [7:0]  mask;
      logic        keyframe;
      logic        restart;
      logic        noise_new;
      logic        shape_new;
      rsp_word_type r;
      int          ch;
      int          k;
      keyframe = w.frame_flags[FF_KEYFRAME];
      tone[0] = w.tone_a_period;
      tone[1] = w.tone_b_period;
      tone[2] = w.tone_c_period;
      for (ch = 0; ch < TONE_CHANNELS; ch++) begin
         cur[2*ch]   = tone[ch][7:0];
         cur[2*ch+1] = {4'h0, tone[ch][11:8]};
      end
      cur[R_NOISE]   = {3'b000, w.noise_period};
      cur[R_MIXER]   = w.mixer_bits;
      cur[R_LEVEL_A] = {3'b000, w.level_a};
      cur[R_LEVEL_B] = {3'b000, w.level_b};
      cur[R_LEVEL_C] = {3'b000, w.level_c};
      cur[R_ENV_LO]  = w.envelope_period[7:0];
      cur[R_ENV_HI]  = w.envelope_period[15:8];
      cur[R_SHAPE]   = {4'h0, w.envelope_shape};
      mask = 8'h00;

      // mixer high bits are stored but never compared
      if (((cur[R_MIXER] & MIXER_MASK) != (kept_regs[R_MIXER] & MIXER_MASK)) || keyframe) begin
         mask[M_MIXER] = 1'b1;
         rec.push_back((cur[R_MIXER] & MIXER_MASK) | MIXER_TAG);
      end
      for (ch = 0; ch < TONE_CHANNELS; ch++) begin
         restart = w.retrigger_flags[ch];
         if (cur[2*ch] != kept_regs[2*ch] || cur[2*ch+1] != kept_regs[2*ch+1] ||
             restart || keyframe) begin
            mask[M_TONE_A-ch] = 1'b1;
            rec.push_back(cur[2*ch]);
            rec.push_back(restart ? (cur[2*ch+1] | FLAG_BIT) : cur[2*ch+1]);
         end
      end
      if (cur[R_ENV_LO] != kept_regs[R_ENV_LO] || cur[R_ENV_HI] != kept_regs[R_ENV_HI] ||
          keyframe) begin
         mask[M_ENV] = 1'b1;
         rec.push_back(cur[R_ENV_LO]);
         rec.push_back(cur[R_ENV_HI]);
      end
      noise_new = (cur[R_NOISE] != kept_regs[R_NOISE]);
      if (cur[R_LEVEL_A] != kept_regs[R_LEVEL_A] || noise_new || keyframe) begin
         mask[M_LEVEL_A] = 1'b1;
         if (noise_new) begin
            rec.push_back(cur[R_LEVEL_A] | FLAG_BIT);
            rec.push_back(cur[R_NOISE]);
         end else begin
            rec.push_back(cur[R_LEVEL_A]);
         end
      end
      shape_new = (cur[R_SHAPE] != kept_regs[R_SHAPE]) || w.retrigger_flags[RT_SHAPE];
      if (cur[R_LEVEL_B] != kept_regs[R_LEVEL_B] || shape_new || keyframe) begin
         mask[M_LEVEL_B] = 1'b1;
         if (shape_new) begin
            rec.push_back(cur[R_LEVEL_B] | FLAG_BIT);
            rec.push_back(cur[R_SHAPE]);
         end else begin
            rec.push_back(cur[R_LEVEL_B]);
         end
      end
      if (cur[R_LEVEL_C] != kept_regs[R_LEVEL_C] || keyframe) begin
         mask[M_LEVEL_C] = 1'b1;
         rec.push_back(cur[R_LEVEL_C]);
      end
      rec.push_front(mask);
      kept_regs = cur;

      if (w.frame_flags[FF_EMIT]) begin
         for (k = 0; k < rec.size(); k++) begin
            r.data_byte = rec[k];
            r.last_byte = (k == rec.size() - 1);
            expected_bytes.push_back(r);
         end
      end
   endfunction

   // idle cycles before a word on either side
   function automatic int draw_wait();
      if (gaps_on && $urandom_range(0, 2) == 0)
         return int'($urandom_range(0, 16));
      return 0;
   endfunction

   // next snapshot of a random sequence: sparse changes, sometimes a fresh one
   function automatic req_word_type next_frame(input req_word_type base);
      logic [95:0]  bits;
      req_word_type fresh;
      req_word_type w;
      bits  = {$urandom, $urandom, $urandom};
      fresh = bits[$bits(req_word_type)-1:0];
      w     = base;
      if ($urandom_range(0, 7) == 0) begin
         w = fresh;
      end else begin
         if ($urandom_range(0, 3) == 0) w.mixer_bits      = fresh.mixer_bits;
         if ($urandom_range(0, 3) == 0) w.tone_a_period   = fresh.tone_a_period;
         if ($urandom_range(0, 3) == 0) w.tone_b_period   = fresh.tone_b_period;
         if ($urandom_range(0, 3) == 0) w.tone_c_period   = fresh.tone_c_period;
         if ($urandom_range(0, 4) == 0) w.envelope_period = fresh.envelope_period;
         if ($urandom_range(0, 4) == 0) w.noise_period    = fresh.noise_period;
         if ($urandom_range(0, 3) == 0) w.level_a         = fresh.level_a;
         if ($urandom_range(0, 3) == 0) w.level_b         = fresh.level_b;
         if ($urandom_range(0, 3) == 0) w.level_c         = fresh.level_c;
         if ($urandom_range(0, 5) == 0) w.envelope_shape  = fresh.envelope_shape;
      end
      w.retrigger_flags = ($urandom_range(0, 3) == 0) ? fresh.retrigger_flags : 4'h0;
      w.frame_flags[FF_EMIT]     = ($urandom_range(0, 9) != 0);
      w.frame_flags[FF_KEYFRAME] = ($urandom_range(0, 9) == 0);
      return w;
   endfunction

   // valid stays high on return so a following word can go out back to back
   task automatic send_frame(input req_word_type w);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      predict_record(w);
      last_frame = w;
      frames_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      req_word_type w;
      int           ch;
      w = '0;
      w.frame_flags[FF_EMIT] = 1'b1;
      send_frame(w);                         // nothing changed: lone mask byte
      w.frame_flags[FF_KEYFRAME] = 1'b1;
      send_frame(w);                         // keyframe of an all-zero file
      w = '1;
      send_frame(w);                         // every field at its top value
      w.retrigger_flags = 4'h0;
      w.frame_flags     = 2'b00;
      w.frame_flags[FF_EMIT] = 1'b1;
      send_frame(w);
      w.mixer_bits = 8'h3F;                  // only the ignored mixer bits move
      send_frame(w);
      for (ch = 0; ch <= RT_SHAPE; ch++) begin
         w.retrigger_flags = 4'h0;
         w.retrigger_flags[ch] = 1'b1;       // restart / reselect without a change
         send_frame(w);
      end
      w.retrigger_flags = 4'h0;
      w.noise_period    = 5'd5;
      send_frame(w);
      w.envelope_shape  = 4'd3;
      send_frame(w);
      w.mixer_bits      = 8'h15;
      send_frame(w);
      w.tone_a_period   = 12'h123;
      send_frame(w);
      w.tone_b_period   = 12'h800;
      send_frame(w);
      w.tone_c_period   = 12'h0FF;
      send_frame(w);
      w.envelope_period = 16'hFF00;
      send_frame(w);
      w.level_a         = 5'h10;
      send_frame(w);
      w.level_b         = 5'h00;
      send_frame(w);
      w.level_c         = 5'h0F;
      send_frame(w);
      w = '0;                                // emit off, copy still updated
      send_frame(w);
      w.frame_flags[FF_EMIT] = 1'b1;
      send_frame(w);
      w.noise_period    = 5'd31;             // keyframe with noise and shape news
      w.envelope_shape  = 4'd9;
      w.frame_flags[FF_KEYFRAME] = 1'b1;
      send_frame(w);
      w.frame_flags     = 2'b00;
      w.frame_flags[FF_KEYFRAME] = 1'b1;     // keyframe with emit off
      send_frame(w);
      wait_drained();
   endtask

   task automatic test_random_frames(input int count);
      int n;
      for (n = 0; n < count; n++)
         send_frame(next_frame(last_frame));
      wait_drained();
   endtask

   // output held off while snapshots keep coming, so the queue fills up
   task automatic test_output_holdoff(input int count);
      int n;
      gaps_on      = 1'b0;
      hold_request = HOLD_CYCLES;
      for (n = 0; n < count; n++)
         send_frame(next_frame(last_frame));
      gaps_on = 1'b1;
      wait_drained();
   endtask

   task automatic test_back_to_back(input int count);
      int n;
      gaps_on = 1'b0;
      for (n = 0; n < count; n++)
         send_frame(next_frame(last_frame));
      wait_drained();
      gaps_on = 1'b1;
   endtask

   // output side stall: a long hold when asked, else a fresh draw per word
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (rsp_valid && !rsp_stall)
         stall_left = draw_wait();
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: word with none expected: data_byte %02h last_byte %0b",
                     $time, rsp_word.data_byte, rsp_word.last_byte);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_word.data_byte !== want.data_byte) begin
               $display("%0t: data_byte expected %02h actual %02h",
                        $time, want.data_byte, rsp_word.data_byte);
               fail_count++;
            end
            if (rsp_word.last_byte !== want.last_byte) begin
               $display("%0t: last_byte expected %0b actual %0b",
                        $time, want.last_byte, rsp_word.last_byte);
               fail_count++;
            end
            words_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d words still expected",
                  $time, CYCLE_LIMIT, expected_bytes.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      foreach (kept_regs[i]) kept_regs[i] = 8'h00;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_frames(190);
      test_output_holdoff(24);
      test_back_to_back(30);
      if (expected_bytes.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, expected_bytes.size());
         fail_count++;
      end
      $display("%0d snapshots sent, %0d encoded words checked", frames_sent, words_checked);
      $display("covered corner frames, random sequences, output hold-off, back-to-back");
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
